[hw/rtl/lzw_pkg.sv]
// ----------------------------------------------------------------------------
// LZW encoder package
// Item types, controller states and fixed constants shared by the encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

    // Emitted code field width on the output channel
    localparam int CODE_BITS = 12;

    // First code handed to a learned string; 256 is never used
    localparam int FIRST_LEARNED = 257;

    // Message generation tag kept in every hash slot
    localparam int EPOCH_W = 8;

    // Result queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        code_t code;
        logic  end_of_message;
    } code_item_t;

    // Result queue status seen by the controller
    typedef struct packed {
        logic not_empty;
        logic room_for_two;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FLUSH
    } enc_state_t;

endpackage

[hw/rtl/lzw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lzw_out_fifo.sv]
// ----------------------------------------------------------------------------
// LZW result queue
// Small queue between the encoder core and the code channel; lets the core
// take the next byte while earlier codes wait for the receiver.
// ----------------------------------------------------------------------------
module lzw_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lzw_pkg::code_item_t push_item,
    input  logic                pop,
    output lzw_pkg::code_item_t head_item,
    output lzw_pkg::fifo_stat_t stat
);

    lzw_pkg::code_item_t              slots_reg [lzw_pkg::FIFO_DEPTH];
    logic [lzw_pkg::FIFO_AW-1:0]      head_reg;
    logic [lzw_pkg::FIFO_AW-1:0]      head_next;
    logic [lzw_pkg::FIFO_AW-1:0]      tail_reg;
    logic [lzw_pkg::FIFO_AW-1:0]      tail_next;
    logic [lzw_pkg::FIFO_CW-1:0]      count_reg;
    logic [lzw_pkg::FIFO_CW-1:0]      count_next;

    // Advance pointers and count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Hold queued codes
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[tail_reg] <= push_item;
        end
    end

    assign head_item         = slots_reg[head_reg];
    assign stat.not_empty    = (count_reg != '0);
    assign stat.room_for_two =
        (count_reg <= lzw_pkg::FIFO_CW'(lzw_pkg::FIFO_DEPTH - 2));

endmodule

[hw/rtl/lzw_byte_encoder.sv]
// ----------------------------------------------------------------------------
// LZW byte encoder
// Takes one message byte per request and emits LZW dictionary codes.
//   byte channel: one request per message byte, last_byte set on the final
//   byte. code channel: emitted codes, end_of_message on the final code of
//   each message. Codes 0..255 are single bytes, learned strings are
//   numbered from 257 upward until the dictionary is full.
//   The dictionary lives in a hash table of 2^(CODE_WIDTH+1) slots in one
//   RAM with registered read, searched by linear probing. Each byte is
//   accepted and then probes slot after slot (usually one or two) until a
//   hit or an empty slot; a miss on the last byte adds a flush step for the
//   final code. The first byte of a message is taken without a probe. A
//   decided code is registered in the result queue before it is output.
//   Every slot carries a message tag; ending a message bumps the tag so
//   the dictionary empties at once. After reset, and after every 255th
//   message when the tag wraps, a clearing pass writes all
//   2^(CODE_WIDTH+1) slots, one per cycle, while no byte is taken.
//   Codes queue in a four-entry buffer; when the receiver stalls the block
//   keeps taking bytes while two free entries remain, then holds off.
// ----------------------------------------------------------------------------
module lzw_byte_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  lzw_pkg::byte_item_t byte_item,
    output logic                code_valid,
    input  logic                code_ready,
    output lzw_pkg::code_item_t code_item
);

    localparam int CODE_WIDTH = lzw_pkg::CODE_BITS;
    localparam int SLOT_AW    = CODE_WIDTH + 1;
    localparam int SLOT_DEPTH = 1 << SLOT_AW;
    localparam int BYTE_LSB   = CODE_WIDTH;
    localparam int PREFIX_LSB = CODE_WIDTH + 8;
    localparam int EPOCH_LSB  = 2 * CODE_WIDTH + 8;
    localparam int SLOT_W     = 2 * CODE_WIDTH + 8 + lzw_pkg::EPOCH_W;

    lzw_pkg::enc_state_t              state_reg;
    lzw_pkg::enc_state_t              state_next;

    logic [CODE_WIDTH-1:0]            current_code_reg;
    logic [CODE_WIDTH-1:0]            current_code_next;
    logic                             have_current_reg;
    logic                             have_current_next;
    logic [CODE_WIDTH:0]              next_free_reg;
    logic [CODE_WIDTH:0]              next_free_next;
    logic [lzw_pkg::EPOCH_W-1:0]      epoch_reg;
    logic [lzw_pkg::EPOCH_W-1:0]      epoch_next;
    logic [SLOT_AW-1:0]               probe_addr_reg;
    logic [SLOT_AW-1:0]               probe_addr_next;
    logic [SLOT_AW-1:0]               clr_idx_reg;
    logic [SLOT_AW-1:0]               clr_idx_next;
    logic [7:0]                       byte_reg;
    logic [7:0]                       byte_next;
    logic                             last_reg;
    logic                             last_next;

    logic                             accept;
    logic                             epoch_wrap;
    logic [SLOT_AW-1:0]               home_addr;
    logic                             ram_we;
    logic [SLOT_AW-1:0]               ram_waddr;
    logic [SLOT_W-1:0]                ram_wdata;
    logic [SLOT_AW-1:0]               ram_raddr;
    logic [SLOT_W-1:0]                ram_rdata;
    logic                             slot_live;
    logic                             slot_match;
    logic [CODE_WIDTH-1:0]            slot_code;
    logic                             push;
    lzw_pkg::code_item_t              push_item;
    lzw_pkg::fifo_stat_t              fifo_stat;

    // Request handshake
    assign byte_ready = (state_reg == lzw_pkg::ST_IDLE) && fifo_stat.room_for_two;
    assign accept     = byte_valid && byte_ready;
    assign epoch_wrap = (epoch_reg == '1);

    // Home slot of (current code, byte) for the incoming request
    assign home_addr = {1'b0, current_code_reg}
                     ^ {byte_item.data_byte, {(SLOT_AW - 8){1'b0}}};

    // Decode the slot read last cycle
    assign slot_code  = ram_rdata[CODE_WIDTH-1:0];
    assign slot_live  = (ram_rdata[EPOCH_LSB +: lzw_pkg::EPOCH_W] == epoch_reg);
    assign slot_match = slot_live
                     && (ram_rdata[PREFIX_LSB +: CODE_WIDTH] == current_code_reg)
                     && (ram_rdata[BYTE_LSB +: 8] == byte_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzw_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = lzw_pkg::ST_IDLE;
                end
            end
            lzw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!have_current_reg)
                    begin
                        if (byte_item.last_byte && epoch_wrap)
                        begin
                            state_next = lzw_pkg::ST_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next = lzw_pkg::ST_LOOK;
                    end
                end
            end
            lzw_pkg::ST_LOOK:
            begin
                if (slot_match)
                begin
                    if (last_reg && epoch_wrap)
                    begin
                        state_next = lzw_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = lzw_pkg::ST_IDLE;
                    end
                end
                else if (!slot_live)
                begin
                    state_next = last_reg ? lzw_pkg::ST_FLUSH : lzw_pkg::ST_IDLE;
                end
            end
            lzw_pkg::ST_FLUSH:
            begin
                state_next = epoch_wrap ? lzw_pkg::ST_CLEAR : lzw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lzw_pkg::ST_CLEAR;
            end
        endcase
    end

    // Datapath, memory and result controls
    always_comb
    begin
        logic end_msg;

        end_msg           = 1'b0;
        current_code_next = current_code_reg;
        have_current_next = have_current_reg;
        next_free_next    = next_free_reg;
        epoch_next        = epoch_reg;
        probe_addr_next   = probe_addr_reg;
        clr_idx_next      = clr_idx_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;
        ram_waddr         = probe_addr_reg;
        ram_wdata         = {epoch_reg, current_code_reg, byte_reg,
                             next_free_reg[CODE_WIDTH-1:0]};
        ram_raddr         = probe_addr_reg + 1'b1;
        push              = 1'b0;
        push_item.code           = lzw_pkg::code_t'(current_code_reg);
        push_item.end_of_message = 1'b0;

        case (state_reg)
            lzw_pkg::ST_CLEAR:
            begin
                // Sweep all slots to the empty tag
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            lzw_pkg::ST_IDLE:
            begin
                ram_raddr = home_addr;
                if (accept)
                begin
                    byte_next       = byte_item.data_byte;
                    last_next       = byte_item.last_byte;
                    probe_addr_next = home_addr;
                    if (!have_current_reg)
                    begin
                        // First byte of a message: start from the byte itself
                        current_code_next = CODE_WIDTH'(byte_item.data_byte);
                        have_current_next = 1'b1;
                        if (byte_item.last_byte)
                        begin
                            push                     = 1'b1;
                            push_item.code           =
                                lzw_pkg::code_t'(byte_item.data_byte);
                            push_item.end_of_message = 1'b1;
                            end_msg                  = 1'b1;
                        end
                    end
                end
            end
            lzw_pkg::ST_LOOK:
            begin
                if (slot_match)
                begin
                    // Hit: extend the current string
                    current_code_next = slot_code;
                    if (last_reg)
                    begin
                        push                     = 1'b1;
                        push_item.code           = lzw_pkg::code_t'(slot_code);
                        push_item.end_of_message = 1'b1;
                        end_msg                  = 1'b1;
                    end
                end
                else if (slot_live)
                begin
                    // Occupied by another string: probe the next slot
                    probe_addr_next = probe_addr_reg + 1'b1;
                end
                else
                begin
                    // Miss: emit, learn if room, restart from the byte
                    push              = 1'b1;
                    current_code_next = CODE_WIDTH'(byte_reg);
                    if (!next_free_reg[CODE_WIDTH])
                    begin
                        ram_we         = 1'b1;
                        next_free_next = next_free_reg + 1'b1;
                    end
                end
            end
            lzw_pkg::ST_FLUSH:
            begin
                // Final code after a miss on the last byte
                push                     = 1'b1;
                push_item.end_of_message = 1'b1;
                end_msg                  = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Close the message: empty the dictionary by moving to a new tag
        if (end_msg)
        begin
            current_code_next = '0;
            have_current_next = 1'b0;
            next_free_next    = (CODE_WIDTH + 1)'(lzw_pkg::FIRST_LEARNED);
            epoch_next        = epoch_wrap ? lzw_pkg::EPOCH_W'(1) : epoch_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lzw_pkg::ST_CLEAR;
            current_code_reg <= '0;
            have_current_reg <= 1'b0;
            next_free_reg    <= (CODE_WIDTH + 1)'(lzw_pkg::FIRST_LEARNED);
            epoch_reg        <= lzw_pkg::EPOCH_W'(1);
            clr_idx_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            current_code_reg <= current_code_next;
            have_current_reg <= have_current_next;
            next_free_reg    <= next_free_next;
            epoch_reg        <= epoch_next;
            clr_idx_reg      <= clr_idx_next;
        end
    end

    // Request payload and probe address
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        probe_addr_reg <= probe_addr_next;
    end

    // Dictionary hash table
    lzw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_DEPTH)
    ) u_dict_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result queue
    lzw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (code_valid && code_ready),
        .head_item (code_item),
        .stat      (fifo_stat)
    );

    assign code_valid = fifo_stat.not_empty;

endmodule

[verif/lzw_byte_encoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW byte encoder testbench
// Sends byte messages through the byte channel and checks every emitted code
// against an in-bench LZW encoder. The directed messages cover the first
// byte, hits, misses and the last byte. The random messages are mostly drawn
// from small alphabets so that long strings are learned. Enough short
// messages are sent to wrap the message tag, and one long message fills the
// dictionary. The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_test;

    localparam int DICT_ENTRIES   = 1 << lzw_pkg::CODE_BITS;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int SHORT_MESSAGES = 300;

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    lzw_pkg::byte_item_t byte_item;
    logic                code_valid;
    logic                code_ready;
    lzw_pkg::code_item_t code_item;

    // Encoder state mirrored by the bench
    int                  learned_codes [bit [lzw_pkg::CODE_BITS+7:0]];
    int                  free_code;
    lzw_pkg::code_t      match_code;
    bit                  matching;

    lzw_pkg::code_item_t pending_codes [$];
    logic [7:0]          message_bytes [$];
    int                  mismatches;
    int                  burst_left;
    bit                  gaps_on;

    lzw_byte_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_item (byte_item),
        .code_valid(code_valid),
        .code_ready(code_ready),
        .code_item (code_item)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bound the run
    initial
    begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end

    // Append one expected code to the pending list
    function automatic void queue_expected(input lzw_pkg::code_t code, input logic eom);
        lzw_pkg::code_item_t item;
        item.code           = code;
        item.end_of_message = eom;
        pending_codes.insert(pending_codes.size(), item);
    endfunction

    // Append one byte to the message being built
    function automatic void add_message_byte(input logic [7:0] data);
        message_bytes.insert(message_bytes.size(), data);
    endfunction

    // Work out the codes that one accepted byte emits
    function automatic void predict_codes(input logic [7:0] data, input logic last);
        bit [lzw_pkg::CODE_BITS+7:0] key;
        if (!matching)
        begin
            match_code = lzw_pkg::code_t'(data);
            matching   = 1'b1;
        end
        else
        begin
            key = {match_code, data};
            if (learned_codes.exists(key))
            begin
                match_code = lzw_pkg::code_t'(learned_codes[key]);
            end
            else
            begin
                queue_expected(match_code, 1'b0);
                if (free_code < DICT_ENTRIES)
                begin
                    learned_codes[key] = free_code;
                    free_code++;
                end
                match_code = lzw_pkg::code_t'(data);
            end
        end
        if (last)
        begin
            queue_expected(match_code, 1'b1);
            learned_codes.delete();
            free_code  = lzw_pkg::FIRST_LEARNED;
            match_code = '0;
            matching   = 1'b0;
        end
    endfunction

    // Pick the idle gap before the next request: bursts with gaps between
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return gaps_on ? int'($urandom_range(1, 8)) : 0;
    endfunction

    // Send one byte request and hold it until accepted
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            byte_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid = 1'b1;
        byte_item.data_byte = data;
        byte_item.last_byte = last;
        do @(posedge clk); while (!byte_ready);
        predict_codes(data, last);
    endtask

    // Send the queued message, last flag on its final byte
    task automatic send_message();
        foreach (message_bytes[i])
            send_byte(message_bytes[i], i == message_bytes.size() - 1);
        message_bytes.delete();
    endtask

    // Drop valid and hold off until every pending code has come
    task automatic drain_codes();
        @(negedge clk);
        byte_valid = 1'b0;
        burst_left = 0;
        while (pending_codes.size() != 0) @(posedge clk);
    endtask

    // Directed messages: first byte alone, repeats, alternation, extremes
    task automatic test_single_messages();
        message_bytes = '{8'h00};
        send_message();
        message_bytes = '{8'hFF};
        send_message();
        // miss on the last byte emits two codes
        message_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_message();
        // hit on the last byte emits a learned code
        message_bytes = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
        send_message();
        message_bytes = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h01, 8'hFE};
        send_message();
        drain_codes();
    endtask

    // Many short messages, enough to wrap the message tag
    task automatic test_tag_wrap();
        int len;
        for (int m = 0; m < SHORT_MESSAGES; m++)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                add_message_byte(8'($urandom_range(0, 255)));
            send_message();
        end
        drain_codes();
    endtask

    // Random messages, mostly from small alphabets so strings repeat
    task automatic test_random_messages();
        int         sent;
        int         len;
        int         pick;
        int         symbol_count;
        logic [7:0] symbols [4];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 120);
            symbol_count = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : 0;
            foreach (symbols[i])
                symbols[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++)
            begin
                if (symbol_count == 0)
                    add_message_byte(8'($urandom_range(0, 255)));
                else
                    add_message_byte(symbols[2'($urandom_range(0, symbol_count - 1))]);
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            send_message();
            sent += len;
            // pause until the codes so far are all out
            if ($urandom_range(0, 19) == 0)
                drain_codes();
        end
        gaps_on = 1'b1;
        drain_codes();
    endtask

    // One long message that fills the dictionary and keeps going
    task automatic test_full_dictionary();
        logic [7:0] data;
        while (free_code < DICT_ENTRIES)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        // misses now only restart; hits on learned strings still extend
        for (int i = 0; i < 300; i++)
        begin
            data = (i % 3 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
            send_byte(data, 1'b0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        drain_codes();
    endtask

    // Stall the receiver on stretches of random length
    initial
    begin
        code_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            code_ready = 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat (199) @(negedge clk);
            else
                repeat ($urandom_range(0, 19)) @(negedge clk);
            @(negedge clk);
            code_ready = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    end

    // Check each accepted code against the oldest pending one
    always @(posedge clk)
    begin : check_codes
        lzw_pkg::code_item_t want;
        if (rst_n && code_valid && code_ready)
        begin
            if (pending_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected code %0d end_of_message %0b",
                             code_item.code, code_item.end_of_message);
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code_item.code !== want.code
                    || code_item.end_of_message !== want.end_of_message)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("code mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.code, want.end_of_message,
                                 code_item.code, code_item.end_of_message);
                end
            end
        end
    end

    // Reset, run the tests in turn, then report
    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        mismatches = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        free_code  = lzw_pkg::FIRST_LEARNED;
        match_code = '0;
        matching   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_messages();
        test_tag_wrap();
        test_random_messages();
        test_full_dictionary();

        drain_codes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
